[rtl/tcp8_pkg.sv]
// ----------------------------------------------------------------------------
// tcp8_pkg
// Shared types and codes of the 8-bit timer/counter with compare unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tcp8_pkg;

    localparam int PRESCALE_WIDTH = 10;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH = 8;

    // item codes
    localparam logic [1:0] ITEM_TICK      = 2'd0;
    localparam logic [1:0] ITEM_WR_COUNT  = 2'd1;
    localparam logic [1:0] ITEM_WR_CMP    = 2'd2;
    localparam logic [1:0] ITEM_CLR_FLAGS = 2'd3;

    // waveform modes
    localparam logic [1:0] WGM_NORMAL = 2'd0;
    localparam logic [1:0] WGM_PHASE  = 2'd1;
    localparam logic [1:0] WGM_CTC    = 2'd2;
    localparam logic [1:0] WGM_FAST   = 2'd3;

    // compare output actions
    localparam logic [1:0] COM_OFF    = 2'd0;
    localparam logic [1:0] COM_TOGGLE = 2'd1;
    localparam logic [1:0] COM_CLEAR  = 2'd2;
    localparam logic [1:0] COM_SET    = 2'd3;

    // clock selects
    localparam logic [2:0] CS_STOP    = 3'd0;
    localparam logic [2:0] CS_DIV1    = 3'd1;
    localparam logic [2:0] CS_DIV8    = 3'd2;
    localparam logic [2:0] CS_DIV64   = 3'd3;
    localparam logic [2:0] CS_DIV256  = 3'd4;
    localparam logic [2:0] CS_DIV1024 = 3'd5;
    localparam logic [2:0] CS_MASK    = 3'b111;

    // register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_WAVEFORM = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_OUTPUT   = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_CLOCK    = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_OV_IE    = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_CMP_IE   = 3'd4;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] data;
    } in_item_t;

    typedef struct packed {
        logic [7:0] count_value;
        logic [7:0] compare_level;
        logic       output_pin;
        logic       overflow_flag;
        logic       match_flag;
        logic       irq;
    } out_item_t;

    typedef struct packed {
        logic [1:0] waveform_mode;
        logic [1:0] output_mode;
        logic [2:0] clock_select;
        logic       overflow_irq_enable;
        logic       compare_irq_enable;
    } cfg_t;

endpackage

`default_nettype wire

[rtl/tcp8_prescaler.sv]
// ----------------------------------------------------------------------------
// tcp8_prescaler
// Free-running tick prescaler; flags the timer clock for the selected tap.
// ----------------------------------------------------------------------------
`default_nettype none

module tcp8_prescaler (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       tick,
    input  wire logic [2:0] clock_select,
    output logic            timer_clk
);

    localparam int PW = tcp8_pkg::PRESCALE_WIDTH;

    logic [tcp8_pkg::PRESCALE_WIDTH-1:0] presc_reg;
    logic [tcp8_pkg::PRESCALE_WIDTH-1:0] presc_next;

    always_comb begin
        presc_next = presc_reg + PW'(1);
        unique case (clock_select & tcp8_pkg::CS_MASK)
            tcp8_pkg::CS_DIV1:    timer_clk = tick;
            tcp8_pkg::CS_DIV8:    timer_clk = tick && (presc_next[2:0] == '0);
            tcp8_pkg::CS_DIV64:   timer_clk = tick && (presc_next[5:0] == '0);
            tcp8_pkg::CS_DIV256:  timer_clk = tick && (presc_next[7:0] == '0);
            tcp8_pkg::CS_DIV1024: timer_clk = tick && (presc_next == '0);
            default:              timer_clk = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            presc_reg <= '0;
        end else if (tick) begin
            presc_reg <= presc_next;
        end
    end

endmodule

`default_nettype wire

[rtl/tcp8_core.sv]
// ----------------------------------------------------------------------------
// tcp8_core
// Counter, compare unit, pin and flags; applies one item per enable.
// ----------------------------------------------------------------------------
`default_nettype none

module tcp8_core #(
    parameter int COUNT_WIDTH = 8
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  step,
    input  wire tcp8_pkg::in_item_t                    item,
    input  wire logic                                  cfg_wr,
    input  wire logic [tcp8_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  wire logic [tcp8_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
    output tcp8_pkg::cfg_t                             cfg,
    output tcp8_pkg::out_item_t                        result
);

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX  = '1;
    localparam logic [COUNT_WIDTH-1:0] CNT_ONE  = COUNT_WIDTH'(1);
    localparam logic [COUNT_WIDTH-1:0] CNT_MAXM = CNT_MAX - CNT_ONE;

    tcp8_pkg::cfg_t cfg_reg, cfg_next;

    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [COUNT_WIDTH-1:0] cmp_act_reg, cmp_act_next;
    logic [COUNT_WIDTH-1:0] cmp_buf_reg, cmp_buf_next;
    logic down_reg, down_next;
    logic pin_reg, pin_next;
    logic ovf_reg, ovf_next;
    logic cmpf_reg, cmpf_next;
    logic blk_reg, blk_next;

    logic                   timer_clk;
    logic [COUNT_WIDTH-1:0] wr_value;
    logic                   up;
    logic                   wrap;
    logic                   match;
    logic                   set_level;
    logic                   drive;

    tcp8_prescaler u_presc (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .tick         (step && (item.mode == tcp8_pkg::ITEM_TICK)),
        .clock_select (cfg_reg.clock_select),
        .timer_clk    (timer_clk)
    );

    assign wr_value = COUNT_WIDTH'(item.data);

    always_comb begin
        cfg_next     = cfg_reg;
        count_next   = count_reg;
        cmp_act_next = cmp_act_reg;
        cmp_buf_next = cmp_buf_reg;
        down_next    = down_reg;
        pin_next     = pin_reg;
        ovf_next     = ovf_reg;
        cmpf_next    = cmpf_reg;
        blk_next     = blk_reg;
        up           = 1'b1;
        wrap         = (count_reg == CNT_MAX);
        match        = 1'b0;
        set_level    = 1'b0;
        drive        = 1'b0;

        if (step) begin
            unique case (item.mode)
                tcp8_pkg::ITEM_TICK: begin
                    if (timer_clk) begin
                        blk_next = 1'b0;
                        if (cfg_reg.waveform_mode == tcp8_pkg::WGM_PHASE) begin
                            up = !down_reg;
                            if (up) begin
                                if (wrap) begin
                                    down_next  = 1'b1;
                                    count_next = CNT_MAXM;
                                    up         = 1'b0;
                                end else begin
                                    count_next = count_reg + CNT_ONE;
                                end
                            end else begin
                                if (count_reg == '0) begin
                                    down_next  = 1'b0;
                                    count_next = CNT_ONE;
                                    ovf_next   = 1'b1;
                                    up         = 1'b1;
                                end else begin
                                    count_next = count_reg - CNT_ONE;
                                end
                            end
                            if (up && (count_next == CNT_MAX)) begin
                                cmp_act_next = cmp_buf_reg;
                            end
                            match = !blk_reg && (count_next == cmp_act_next);
                            if (match) begin
                                cmpf_next = 1'b1;
                                drive     = 1'b1;
                                if (cmp_act_next == '0) begin
                                    set_level = 1'b0;
                                end else if (cmp_act_next == CNT_MAX) begin
                                    set_level = 1'b1;
                                end else begin
                                    set_level = !up;
                                end
                            end
                        end else begin
                            down_next = 1'b0;
                            match     = !blk_reg && (count_reg == cmp_act_reg);
                            if (match) begin
                                cmpf_next = 1'b1;
                            end
                            if (wrap) begin
                                ovf_next = 1'b1;
                            end
                            count_next = wrap ? '0 : count_reg + CNT_ONE;
                            if (cfg_reg.waveform_mode == tcp8_pkg::WGM_FAST) begin
                                if (wrap) begin
                                    cmp_act_next = cmp_buf_reg;
                                    drive        = 1'b1;
                                    set_level    = 1'b1;
                                end else if (match) begin
                                    drive     = 1'b1;
                                    set_level = 1'b0;
                                end
                            end else begin
                                if (cfg_reg.waveform_mode == tcp8_pkg::WGM_CTC && match) begin
                                    count_next = '0;
                                end
                                if (match) begin
                                    unique case (cfg_reg.output_mode)
                                        tcp8_pkg::COM_TOGGLE: pin_next = !pin_reg;
                                        tcp8_pkg::COM_CLEAR:  pin_next = 1'b0;
                                        tcp8_pkg::COM_SET:    pin_next = 1'b1;
                                        default:              pin_next = pin_reg;
                                    endcase
                                end
                            end
                        end
                        if (drive) begin
                            if (cfg_reg.output_mode == tcp8_pkg::COM_CLEAR) begin
                                pin_next = set_level;
                            end else if (cfg_reg.output_mode == tcp8_pkg::COM_SET) begin
                                pin_next = !set_level;
                            end
                        end
                    end
                end
                tcp8_pkg::ITEM_WR_COUNT: begin
                    count_next = wr_value;
                    blk_next   = 1'b1;
                end
                tcp8_pkg::ITEM_WR_CMP: begin
                    cmp_buf_next = wr_value;
                    if (cfg_reg.waveform_mode == tcp8_pkg::WGM_NORMAL ||
                        cfg_reg.waveform_mode == tcp8_pkg::WGM_CTC) begin
                        cmp_act_next = wr_value;
                    end
                end
                default: begin
                    if (item.data[0]) begin
                        ovf_next = 1'b0;
                    end
                    if (item.data[1]) begin
                        cmpf_next = 1'b0;
                    end
                end
            endcase
        end

        if (cfg_wr) begin
            unique case (cfg_index)
                tcp8_pkg::REG_WAVEFORM: begin
                    cfg_next.waveform_mode = cfg_data[1:0];
                    if (cfg_data[1:0] == tcp8_pkg::WGM_NORMAL ||
                        cfg_data[1:0] == tcp8_pkg::WGM_CTC) begin
                        cmp_act_next = cmp_buf_reg;
                    end
                end
                tcp8_pkg::REG_OUTPUT: cfg_next.output_mode         = cfg_data[1:0];
                tcp8_pkg::REG_CLOCK:  cfg_next.clock_select        = cfg_data[2:0];
                tcp8_pkg::REG_OV_IE:  cfg_next.overflow_irq_enable = cfg_data[0];
                tcp8_pkg::REG_CMP_IE: cfg_next.compare_irq_enable  = cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg     <= '0;
            count_reg   <= '0;
            cmp_act_reg <= '0;
            cmp_buf_reg <= '0;
            down_reg    <= 1'b0;
            pin_reg     <= 1'b0;
            ovf_reg     <= 1'b0;
            cmpf_reg    <= 1'b0;
            blk_reg     <= 1'b0;
        end else begin
            cfg_reg     <= cfg_next;
            count_reg   <= count_next;
            cmp_act_reg <= cmp_act_next;
            cmp_buf_reg <= cmp_buf_next;
            down_reg    <= down_next;
            pin_reg     <= pin_next;
            ovf_reg     <= ovf_next;
            cmpf_reg    <= cmpf_next;
            blk_reg     <= blk_next;
        end
    end

    assign cfg = cfg_reg;

    always_comb begin
        result.count_value   = 8'(count_next);
        result.compare_level = 8'(cmp_act_next);
        result.output_pin    = pin_next;
        result.overflow_flag = ovf_next;
        result.match_flag    = cmpf_next;
        result.irq           = (ovf_next && cfg_reg.overflow_irq_enable) ||
                               (cmpf_next && cfg_reg.compare_irq_enable);
    end

endmodule

`default_nettype wire

[rtl/timer_counter_pwm_8bit_top.sv]
// ----------------------------------------------------------------------------
// timer_counter_pwm_8bit_top
// 8-bit timer/counter with prescaler, four waveform modes and one compare unit.
//
// s_ channel: one item per beat (tick, counter write, compare write, flag
// clear). m_ channel: one result beat per item with counter, active compare
// value, pin level, sticky flags and irq. cfg_ channel: register writes,
// accepted with cfg_ready always high; write only while idle.
// The input register captures an accepted item; its result is captured in
// the result register once the receiver is ready, and presented from it.
// Throughput: one item per cycle while the receiver is ready; the counter
// update is a single pass of logic between the two registers, and the
// prescaler is a 10-bit counter advanced by each tick.
// Reset (aresetn low, synchronous) clears the valid bits, the timer state,
// the prescaler and the flags.
// When the receiver stalls, the result register holds, the input register
// fills, and s_ready drops once both stages are occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module timer_counter_pwm_8bit_top #(
    parameter int COUNT_WIDTH = 8
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire tcp8_pkg::in_item_t                    s_item,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output tcp8_pkg::out_item_t                        m_item,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [tcp8_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  wire logic [tcp8_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);

    logic                in_valid_reg;
    tcp8_pkg::in_item_t  in_item_reg;
    logic                out_valid_reg;
    tcp8_pkg::out_item_t out_item_reg;
    tcp8_pkg::out_item_t result;
    tcp8_pkg::cfg_t      cfg;
    logic                advance;
    logic                fire;

    assign advance   = !out_valid_reg || m_ready;
    assign fire      = in_valid_reg && advance;
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    tcp8_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (fire),
        .item      (in_item_reg),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .result    (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg <= s_item;
        end
        if (fire) begin
            out_item_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

    a_fire_gives_result : assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> m_valid)
        else $error("accepted item produced no result beat");

    a_ready_low_only_when_full : assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("input stalled without a full pipeline");

    a_stalled_item_held : assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_item_reg)))
        else $error("stalled input item lost");

    a_irq_off_when_disabled : assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && !cfg.overflow_irq_enable && !cfg.compare_irq_enable) |-> !result.irq)
        else $error("irq raised with both enables off");

endmodule

`default_nettype wire
